// ----- sv/gsgs_pkg.sv -----
package gsgs_pkg;

    // Command codes of the input item.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Classified work kinds passed from front to back.
    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_SOLVE = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;
    localparam logic [1:0] K_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_GRID_N   = 2'd0;
    localparam logic [1:0] REG_BOUNDARY = 2'd1;
    localparam logic [1:0] REG_COUPLING = 2'd2;
    localparam logic [1:0] REG_INV_C    = 2'd3;

    // Boundary modes.
    localparam logic [1:0] BND_NEG_LR = 2'd1;
    localparam logic [1:0] BND_NEG_TB = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [6:0]         column;
        logic [6:0]         row;
        logic signed [31:0] guess_value;
        logic signed [31:0] rhs_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
    } t_out;

    typedef struct packed {
        logic [1:0]         kind;
        logic               bad;
        logic [6:0]         column;
        logic [6:0]         row;
        logic signed [31:0] guess_value;
        logic signed [31:0] rhs_value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  boundary_mode;
        logic [31:0] coupling_coef;
        logic [31:0] inv_center_coef;
    } t_cfg;

endpackage

// ----- sv/gsgs_fifo.sv -----
module gsgs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNW-1:0]   r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage is written at the tail only.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- sv/gsgs_front.sv -----
module gsgs_front #(
    parameter int MAX_GRID = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  gsgs_pkg::t_in                 i_item,
    output gsgs_pkg::t_cmd                o_cmd,
    output gsgs_pkg::t_cfg                o_cfg,
    output logic [$clog2(MAX_GRID+2)-1:0] o_n
);
    localparam int CW = $clog2(MAX_GRID + 2);

    logic [6:0]  r_grid_n;
    logic [1:0]  r_mode;
    logic [31:0] r_coup, r_inv;
    logic [15:0] gn16, n16, lim16;
    logic        bad;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_n <= 7'd64;
            r_mode   <= 2'd0;
            r_coup   <= 32'd65536;
            r_inv    <= 32'd536870912;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gsgs_pkg::REG_GRID_N:   r_grid_n <= i_cfg_data[6:0];
                gsgs_pkg::REG_BOUNDARY: r_mode   <= i_cfg_data[1:0];
                gsgs_pkg::REG_COUPLING: r_coup   <= i_cfg_data;
                gsgs_pkg::REG_INV_C:    r_inv    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Grid size in use, clamped to the built range.
    always_comb begin
        gn16 = 16'(r_grid_n);
        if (gn16 == 16'd0) begin
            n16 = 16'd1;
        end else if (gn16 > 16'(MAX_GRID)) begin
            n16 = 16'(MAX_GRID);
        end else begin
            n16 = gn16;
        end
        lim16 = n16 + 16'd1;
    end

    assign o_n   = CW'(n16);
    assign o_cfg = '{boundary_mode: r_mode, coupling_coef: r_coup, inv_center_coef: r_inv};

    // Classify the item and check its cell index against the grid.
    assign bad = (16'(i_item.column) > lim16) || (16'(i_item.row) > lim16);

    always_comb begin
        o_cmd.bad         = 1'b0;
        o_cmd.column      = i_item.column;
        o_cmd.row         = i_item.row;
        o_cmd.guess_value = i_item.guess_value;
        o_cmd.rhs_value   = i_item.rhs_value;
        unique case (i_item.command)
            gsgs_pkg::CMD_LOAD: begin
                o_cmd.kind = gsgs_pkg::K_LOAD;
                o_cmd.bad  = bad;
            end
            gsgs_pkg::CMD_SOLVE: o_cmd.kind = gsgs_pkg::K_SOLVE;
            gsgs_pkg::CMD_READ: begin
                o_cmd.kind = gsgs_pkg::K_READ;
                o_cmd.bad  = bad;
            end
            default: o_cmd.kind = gsgs_pkg::K_NONE;
        endcase
    end
endmodule

// ----- sv/gsgs_back.sv -----
module gsgs_back #(
    parameter int MAX_GRID = 64,
    parameter int SWEEPS   = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gsgs_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_empty,
    output logic                          o_cmd_pop,
    input  gsgs_pkg::t_cfg                i_cfg,
    input  logic [$clog2(MAX_GRID+2)-1:0] i_n,
    output gsgs_pkg::t_out                o_res,
    output logic                          o_res_push,
    input  logic                          i_res_full
);
    localparam int CW     = $clog2(MAX_GRID + 2);
    localparam int STRIDE = MAX_GRID + 2;
    localparam int CELLS  = STRIDE * STRIDE;
    localparam int AW     = $clog2(CELLS);
    localparam int SWW    = $clog2(SWEEPS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RDOUT = 5'd1;
    localparam logic [4:0] S_C0    = 5'd2;
    localparam logic [4:0] S_C1    = 5'd3;
    localparam logic [4:0] S_C2    = 5'd4;
    localparam logic [4:0] S_C3    = 5'd5;
    localparam logic [4:0] S_C4    = 5'd6;
    localparam logic [4:0] S_MA    = 5'd7;
    localparam logic [4:0] S_MB    = 5'd8;
    localparam logic [4:0] S_MC    = 5'd9;
    localparam logic [4:0] S_MD    = 5'd10;
    localparam logic [4:0] S_ME    = 5'd11;
    localparam logic [4:0] S_MF    = 5'd12;
    localparam logic [4:0] S_MG    = 5'd13;
    localparam logic [4:0] S_MH    = 5'd14;
    localparam logic [4:0] S_ERD   = 5'd15;
    localparam logic [4:0] S_EWR   = 5'd16;
    localparam logic [4:0] S_KRD0  = 5'd17;
    localparam logic [4:0] S_KRD1  = 5'd18;
    localparam logic [4:0] S_KWR   = 5'd19;
    localparam logic [4:0] S_DONE  = 5'd20;

    // Grid memories, one write and one registered read port each.
    logic [31:0] r_sol [CELLS];
    logic [31:0] r_srcm [CELLS];
    logic [31:0] r_rdata, r_srdata;

    logic [4:0]  r_state, n_state;
    logic [SWW-1:0] r_sw;
    logic [CW-1:0]  r_i, r_j, r_k;
    logic [1:0]     r_e;

    logic signed [33:0] r_sum;
    logic signed [31:0] r_src;
    logic               r_neg;
    logic [33:0]        r_mag;
    logic [49:0]        r_ph, r_pl;
    logic [50:0]        r_r;
    logic signed [52:0] r_v;
    logic [52:0]        r_mag2;
    logic [52:0]        r_qh;
    logic [63:0]        r_ql;
    logic [54:0]        r_q;
    logic [31:0]        r_a;

    logic [CW-1:0] rc, rr, wc, wr, n1;
    logic [AW-1:0] raddr, waddr;
    logic          we, swe;
    logic [31:0]   wdata, cell_val, edge_val, rdx;
    logic [32:0]   corner_sum;
    logic          edge_neg;

    assign n1 = i_n + 1'b1;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [CW-1:0] r);
        cell_addr = AW'(c) + AW'(STRIDE) * AW'(r);
    endfunction

    function automatic logic [31:0] neg_sat(input logic [31:0] x);
        neg_sat = (x == 32'h8000_0000) ? 32'h7fff_ffff : 32'(-x);
    endfunction

    // Read address selection by step.
    always_comb begin
        rc = r_i;
        rr = r_j;
        unique case (r_state)
            S_IDLE: begin
                rc = CW'(i_cmd.column);
                rr = CW'(i_cmd.row);
            end
            S_C0: rc = r_i - 1'b1;
            S_C1: rc = r_i + 1'b1;
            S_C2: rr = r_j - 1'b1;
            S_C3: rr = r_j + 1'b1;
            S_ERD: begin
                case (r_e)
                    2'd0: begin rc = CW'(1); rr = r_k; end
                    2'd1: begin rc = i_n;    rr = r_k; end
                    2'd2: begin rc = r_k;    rr = CW'(1); end
                    default: begin rc = r_k; rr = i_n; end
                endcase
            end
            S_KRD0: begin
                case (r_e)
                    2'd0: begin rc = CW'(1); rr = '0; end
                    2'd1: begin rc = CW'(1); rr = n1; end
                    2'd2: begin rc = i_n;    rr = '0; end
                    default: begin rc = i_n; rr = n1; end
                endcase
            end
            S_KRD1: begin
                case (r_e)
                    2'd0: begin rc = '0; rr = CW'(1); end
                    2'd1: begin rc = '0; rr = i_n; end
                    2'd2: begin rc = n1; rr = CW'(1); end
                    default: begin rc = n1; rr = i_n; end
                endcase
            end
            default: ;
        endcase
        raddr = cell_addr(rc, rr);
    end

    // Cell update result: clamp the rounded magnitude and restore the sign; also the edge copy and the corner sum.
    always_comb begin
        if (r_neg) begin
            cell_val = (r_q > 55'h0_8000_0000) ? 32'h8000_0000 : 32'(-r_q[31:0]);
        end else begin
            cell_val = (r_q > 55'h0_7fff_ffff) ? 32'h7fff_ffff : r_q[31:0];
        end
        edge_neg   = (r_e[1] == 1'b0) ? (i_cfg.boundary_mode == gsgs_pkg::BND_NEG_LR)
                                      : (i_cfg.boundary_mode == gsgs_pkg::BND_NEG_TB);
        edge_val   = edge_neg ? neg_sat(r_rdata) : r_rdata;
        corner_sum = {r_a[31], r_a} + {r_rdata[31], r_rdata};
    end

    // Write port selection.
    always_comb begin
        we    = 1'b0;
        swe   = 1'b0;
        wc    = r_i;
        wr    = r_j;
        wdata = cell_val;
        unique case (r_state)
            S_IDLE: begin
                wc    = CW'(i_cmd.column);
                wr    = CW'(i_cmd.row);
                wdata = i_cmd.guess_value;
                if (!i_cmd_empty && !i_res_full && i_cmd.kind == gsgs_pkg::K_LOAD
                    && !i_cmd.bad) begin
                    we  = 1'b1;
                    swe = 1'b1;
                end
            end
            S_MH: we = 1'b1;
            S_EWR: begin
                we    = 1'b1;
                wdata = edge_val;
                case (r_e)
                    2'd0: begin wc = '0;  wr = r_k; end
                    2'd1: begin wc = n1;  wr = r_k; end
                    2'd2: begin wc = r_k; wr = '0; end
                    default: begin wc = r_k; wr = n1; end
                endcase
            end
            S_KWR: begin
                we    = 1'b1;
                wdata = corner_sum[32:1];
                case (r_e)
                    2'd0: begin wc = '0; wr = '0; end
                    2'd1: begin wc = '0; wr = n1; end
                    2'd2: begin wc = n1; wr = '0; end
                    default: begin wc = n1; wr = n1; end
                endcase
            end
            default: ;
        endcase
        waddr = cell_addr(wc, wr);
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_sol[waddr] <= wdata;
        end
        if (swe) begin
            r_srcm[waddr] <= i_cmd.rhs_value;
        end
        r_rdata  <= r_sol[raddr];
        r_srdata <= r_srcm[cell_addr(r_i, r_j)];
    end

    // Sequencer state and result hand-off.
    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{value: 32'sd0, status: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == gsgs_pkg::K_SOLVE) begin
                        n_state = S_C0;
                    end else if (i_cmd.kind == gsgs_pkg::K_READ && !i_cmd.bad) begin
                        n_state = S_RDOUT;
                    end else begin
                        o_res_push = 1'b1;
                        o_res      = '{value: 32'sd0, status: i_cmd.bad};
                    end
                end
            end
            S_RDOUT: begin
                o_res_push = 1'b1;
                o_res      = '{value: r_rdata, status: 1'b0};
                n_state    = S_IDLE;
            end
            S_C0: n_state = S_C1;
            S_C1: n_state = S_C2;
            S_C2: n_state = S_C3;
            S_C3: n_state = S_C4;
            S_C4: n_state = S_MA;
            S_MA: n_state = S_MB;
            S_MB: n_state = S_MC;
            S_MC: n_state = S_MD;
            S_MD: n_state = S_ME;
            S_ME: n_state = S_MF;
            S_MF: n_state = S_MG;
            S_MG: n_state = S_MH;
            S_MH: begin
                if (r_j == i_n && r_i == i_n) begin
                    n_state = S_ERD;
                end else begin
                    n_state = S_C0;
                end
            end
            S_ERD: n_state = S_EWR;
            S_EWR: begin
                if (r_e == 2'd3 && r_k == i_n) begin
                    n_state = S_KRD0;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_KRD0: n_state = S_KRD1;
            S_KRD1: n_state = S_KWR;
            S_KWR: begin
                if (r_e != 2'd3) begin
                    n_state = S_KRD0;
                end else if (r_sw == SWW'(SWEEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_C0;
                end
            end
            S_DONE: begin
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sw    <= '0;
            r_i     <= CW'(1);
            r_j     <= CW'(1);
            r_k     <= CW'(1);
            r_e     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_sw <= '0;
                    r_i  <= CW'(1);
                    r_j  <= CW'(1);
                end
                S_MH: begin
                    if (r_j == i_n) begin
                        r_j <= CW'(1);
                        if (r_i == i_n) begin
                            r_i <= CW'(1);
                            r_k <= CW'(1);
                            r_e <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_EWR: begin
                    r_e <= r_e + 1'b1;
                    if (r_e == 2'd3) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_KWR: begin
                    r_e <= r_e + 1'b1;
                    if (r_e == 2'd3) begin
                        r_sw <= r_sw + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Arithmetic datapath, one register after each step.
    assign rdx = r_rdata;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_C1: begin
                r_sum <= 34'($signed(rdx));
                r_src <= $signed(r_srdata);
            end
            S_C2, S_C3, S_C4: r_sum <= r_sum + 34'($signed(rdx));
            S_MA: begin
                r_neg <= r_sum[33];
                r_mag <= r_sum[33] ? 34'(-r_sum) : 34'(r_sum);
            end
            S_MB: begin
                r_ph <= 50'(i_cfg.coupling_coef[31:16]) * 50'(r_mag);
                r_pl <= 50'(i_cfg.coupling_coef[15:0]) * 50'(r_mag);
            end
            S_MC: r_r <= 51'(r_ph) + 51'((51'(r_pl) + 51'h8000) >> 16);
            S_MD: begin
                if (r_neg) begin
                    r_v <= 53'(r_src) - $signed({2'b00, r_r});
                end else begin
                    r_v <= 53'(r_src) + $signed({2'b00, r_r});
                end
            end
            S_ME: begin
                r_neg  <= r_v[52];
                r_mag2 <= r_v[52] ? 53'(-r_v) : 53'(r_v);
            end
            S_MF: begin
                r_qh <= 53'(r_mag2[52:32]) * 53'(i_cfg.inv_center_coef);
                r_ql <= 64'(r_mag2[31:0]) * 64'(i_cfg.inv_center_coef);
            end
            S_MG: r_q <= 55'({r_qh, 1'b0}) + 55'((65'(r_ql) + 65'h4000_0000) >> 31);
            S_KRD1: r_a <= r_rdata;
            default: ;
        endcase
    end
endmodule

// ----- sv/gauss_seidel_grid_solver.sv -----
// Gauss-Seidel relaxation engine for a stable-fluids style grid.
// Input channel: an item (load, solve or read) is taken when push is high
// and full is low. Results: each item gives one result item, shown while
// empty is low and taken when pop is high; results come out in item order.
// Configuration: a separate valid/ready write port (ready always high);
// write registers only while no item is in flight.
// Flow: items pass a two-entry command queue into the grid sequencer.
// A load or an out-of-range item is done in the idle state, a read also
// passes the readout state (one memory read). The length of a solve is
// set by the single read port of the solution memory: each interior
// cell needs four neighbour reads and two multiply steps in sequence.
// Reset clears the queues and sets the configuration registers to their
// defaults; the grid memories are not cleared and must be loaded first.
// When the receiver stalls, results wait in a two-entry result queue and
// the sequencer holds, so the command queue fills and full rises.
module gauss_seidel_grid_solver #(
    parameter int MAX_GRID = 64,
    parameter int SWEEPS   = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    input  logic           push,
    output logic           full,
    input  gsgs_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output gsgs_pkg::t_out o_result
);
    localparam int CW = $clog2(MAX_GRID + 2);

    gsgs_pkg::t_cmd cmd_in, cmd_out;
    gsgs_pkg::t_cfg cfg;
    gsgs_pkg::t_out res_in;
    logic [CW-1:0]  n;
    logic           cmd_empty, cmd_pop, res_push, res_full;

    gsgs_front #(.MAX_GRID(MAX_GRID)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .o_cmd       (cmd_in),
        .o_cfg       (cfg),
        .o_n         (n)
    );

    gsgs_fifo #(.WIDTH($bits(gsgs_pkg::t_cmd)), .DEPTH(2)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    gsgs_back #(.MAX_GRID(MAX_GRID), .SWEEPS(SWEEPS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (cfg),
        .i_n         (n),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    gsgs_fifo #(.WIDTH($bits(gsgs_pkg::t_out)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );
endmodule

// ----- sv/gsgs_checker.sv -----
module gsgs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           push,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input gsgs_pkg::t_out o_result
);
    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset leaves the input side open.
    a_reset_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    // An index error never carries a cell value.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status) |-> (o_result.value == 32'sd0))
        else $error("error result with non-zero value");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");
endmodule

bind gauss_seidel_grid_solver gsgs_checker u_chk (.*);

// ----- tb/gauss_seidel_grid_solver_tb.sv -----
`timescale 1ns / 100ps

module gauss_seidel_grid_solver_tb;

    localparam int          MAX_GRID = 64;
    localparam int          SWEEPS   = 20;
    localparam int          STRIDE   = MAX_GRID + 2;
    localparam int          CELLS    = STRIDE * STRIDE;
    localparam int          STALL_LIMIT = 100000;
    localparam int          ITEM_GOAL   = 1150;
    localparam logic [1:0]  CMD_NOP  = 2'd3;
    localparam logic [1:0]  BND_MIRROR_ALT = 2'd3;

    // Software copy of the grids and registers; predicts every result item.
    class grid_mirror;
        logic signed [31:0] sol [CELLS];
        logic signed [31:0] src [CELLS];
        bit                 loaded [CELLS];
        logic [6:0]         grid_n;
        logic [1:0]         bnd_mode;
        logic [31:0]        coupling;
        logic [31:0]        inv_c;
        gsgs_pkg::t_out     expected_readouts [$];
        int                 fails;

        function new();
            grid_n   = 7'd64;
            bnd_mode = 2'd0;
            coupling = 32'd65536;
            inv_c    = 32'd536870912;
            fails    = 0;
            foreach (loaded[k]) begin
                loaded[k] = 1'b0;
                sol[k]    = '0;
                src[k]    = '0;
            end
        endfunction

        function int active_n();
            if (grid_n == 0) return 1;
            if (grid_n > MAX_GRID) return MAX_GRID;
            return grid_n;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                gsgs_pkg::REG_GRID_N:   grid_n   = data[6:0];
                gsgs_pkg::REG_BOUNDARY: bnd_mode = data[1:0];
                gsgs_pkg::REG_COUPLING: coupling = data;
                gsgs_pkg::REG_INV_C:    inv_c    = data;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] sat(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [31:0] negate(logic signed [31:0] x);
            return sat(-longint'(x));
        endfunction

        // Neighbour sum times a, back to Q16.16 rounding half away from zero.
        function longint scale_by_coupling(longint s);
            bit          neg;
            bit [63:0]   mag, hi, lo, r;
            neg = s < 0;
            mag = neg ? -s : s;
            hi  = 64'(coupling[31:16]) * mag;
            lo  = 64'(coupling[15:0]) * mag;
            r   = hi + ((lo + 64'h8000) >> 16);
            return neg ? -longint'(r) : longint'(r);
        endfunction

        // Multiply by 1/c (Q1.31), round half away from zero, saturate.
        function logic signed [31:0] scale_by_inverse(longint v);
            bit          neg;
            bit [63:0]   mag, vh, vl, r;
            neg = v < 0;
            mag = neg ? -v : v;
            vh  = mag >> 32;
            vl  = mag & 64'hffffffff;
            r   = ((vh * 64'(inv_c)) << 1) + ((vl * 64'(inv_c) + 64'h40000000) >> 31);
            if (r > 64'h80000000) r = 64'h80000000;
            return sat(neg ? -longint'(r) : longint'(r));
        endfunction

        function logic signed [31:0] corner(logic signed [31:0] p, logic signed [31:0] q);
            longint s;
            s = longint'(p) + longint'(q);
            return 32'(s >>> 1);
        endfunction

        function int at(int i, int j);
            return i + STRIDE * j;
        endfunction

        function void fix_boundary(int n);
            for (int k = 1; k <= n; k++) begin
                sol[at(0, k)]     = bnd_mode == gsgs_pkg::BND_NEG_LR ? negate(sol[at(1, k)])
                                                                    : sol[at(1, k)];
                sol[at(n + 1, k)] = bnd_mode == gsgs_pkg::BND_NEG_LR ? negate(sol[at(n, k)])
                                                                    : sol[at(n, k)];
                sol[at(k, 0)]     = bnd_mode == gsgs_pkg::BND_NEG_TB ? negate(sol[at(k, 1)])
                                                                    : sol[at(k, 1)];
                sol[at(k, n + 1)] = bnd_mode == gsgs_pkg::BND_NEG_TB ? negate(sol[at(k, n)])
                                                                    : sol[at(k, n)];
            end
            sol[at(0, 0)]         = corner(sol[at(1, 0)], sol[at(0, 1)]);
            sol[at(0, n + 1)]     = corner(sol[at(1, n + 1)], sol[at(0, n)]);
            sol[at(n + 1, 0)]     = corner(sol[at(n, 0)], sol[at(n + 1, 1)]);
            sol[at(n + 1, n + 1)] = corner(sol[at(n, n + 1)], sol[at(n + 1, n)]);
        endfunction

        function void relax(int n);
            longint s;
            for (int sw = 0; sw < SWEEPS; sw++) begin
                for (int i = 1; i <= n; i++) begin
                    for (int j = 1; j <= n; j++) begin
                        s = longint'(sol[at(i - 1, j)]) + sol[at(i + 1, j)]
                          + sol[at(i, j - 1)] + sol[at(i, j + 1)];
                        sol[at(i, j)] = scale_by_inverse(longint'(src[at(i, j)])
                                                         + scale_by_coupling(s));
                    end
                end
                fix_boundary(n);
            end
        endfunction

        // Called for each accepted input item.
        function void note_command(gsgs_pkg::t_in it);
            gsgs_pkg::t_out r;
            int             n;
            n = active_n();
            r = '0;
            if (it.command == gsgs_pkg::CMD_LOAD || it.command == gsgs_pkg::CMD_READ) begin
                if (it.column > n + 1 || it.row > n + 1) begin
                    r.status = 1'b1;
                end else if (it.command == gsgs_pkg::CMD_LOAD) begin
                    sol[at(it.column, it.row)]    = it.guess_value;
                    src[at(it.column, it.row)]    = it.rhs_value;
                    loaded[at(it.column, it.row)] = 1'b1;
                end else begin
                    r.value = sol[at(it.column, it.row)];
                end
            end else if (it.command == gsgs_pkg::CMD_SOLVE) begin
                relax(n);
            end
            expected_readouts.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            fails++;
        endtask

        // Called for each accepted result item.
        task check_readout(gsgs_pkg::t_out got);
            gsgs_pkg::t_out exp;
            if (expected_readouts.size() == 0) begin
                report_mismatch("result item with nothing expected");
                return;
            end
            exp = expected_readouts.pop_front();
            if (got.value !== exp.value)
                report_mismatch($sformatf("value %h, expected %h", got.value, exp.value));
            if (got.status !== exp.status)
                report_mismatch($sformatf("status %b, expected %b", got.status, exp.status));
        endtask
    endclass

    logic           i_clk;
    logic           i_rst_n     = 1'b0;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index = '0;
    logic [31:0]    i_cfg_data  = '0;
    logic           push        = 1'b0;
    logic           full;
    gsgs_pkg::t_in  i_item      = '0;
    logic           empty;
    logic           pop         = 1'b0;
    gsgs_pkg::t_out o_result;

    grid_mirror  mirror;
    int          send_idle = 19;
    int          recv_idle = 72;
    int          items_sent = 0;
    int          quiet_cycles = 0;

    gauss_seidel_grid_solver #(.MAX_GRID(MAX_GRID), .SWEEPS(SWEEPS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: pop at random according to the current stall rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitors and stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) mirror.note_command(i_item);
            if (pop && !empty) mirror.check_readout(o_result);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("gauss_seidel_grid_solver test failed");
                $finish;
            end
        end
    end

    task automatic send_item(input gsgs_pkg::t_in it);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        if (it.command != CMD_NOP) items_sent++;
    endtask

    // Lower push and wait until every expected result item is back.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (mirror.expected_readouts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mirror.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: case ($urandom_range(3))
                   0: return 32'h80000000;
                   1: return 32'h7fffffff;
                   2: return 32'h0;
                   default: return 32'hffffffff;
               endcase
            default: return $urandom_range(32'h000fffff) - 32'h00080000;
        endcase
    endfunction

    function automatic gsgs_pkg::t_in make_item(logic [1:0] cmd, int c, int r);
        gsgs_pkg::t_in it;
        it.command     = cmd;
        it.column      = 7'(c);
        it.row         = 7'(r);
        it.guess_value = pick_value();
        it.rhs_value   = pick_value();
        return it;
    endfunction

    task automatic load_square(input int n);
        for (int j = 0; j <= n + 1; j++)
            for (int i = 0; i <= n + 1; i++)
                send_item(make_item(gsgs_pkg::CMD_LOAD, i, j));
    endtask

    // One random phase: new settings, then a mix of commands.
    task automatic run_phase();
        int          n, c, r, roll, ops;
        logic [31:0] a, inv;
        roll = $urandom_range(19);
        if (roll == 0)      write_reg(gsgs_pkg::REG_GRID_N, 32'd0);
        else if (roll == 1) write_reg(gsgs_pkg::REG_GRID_N, 32'd127);
        else if (roll == 2) write_reg(gsgs_pkg::REG_GRID_N, 32'd64);
        else if (roll < 5)  write_reg(gsgs_pkg::REG_GRID_N,
                                      $urandom_range(5, 6) | ($urandom & 32'hffffff80));
        else                write_reg(gsgs_pkg::REG_GRID_N, $urandom_range(1, 4));
        write_reg(gsgs_pkg::REG_BOUNDARY, $urandom_range(3) | ($urandom & 32'hfffffffc));
        case ($urandom_range(3))
            0: begin a = pick_value(); inv = $urandom; end
            1: begin a = $urandom_range(32'h20000); inv = $urandom_range(32'h80000000); end
            default: begin
                a   = $urandom_range(32'h18000, 32'h8000);
                inv = $urandom_range(32'h10000000, 32'h4000000);
            end
        endcase
        write_reg(gsgs_pkg::REG_COUPLING, a);
        write_reg(gsgs_pkg::REG_INV_C, inv);
        n = mirror.active_n();
        if (n <= 6) load_square(n);
        ops = $urandom_range(30, 50);
        for (int k = 0; k < ops; k++) begin
            roll = $urandom_range(99);
            c = $urandom_range(n + 1);
            r = $urandom_range(n + 1);
            if (roll < 5 && n <= 6) begin
                send_item(make_item(gsgs_pkg::CMD_SOLVE, $urandom, $urandom));
            end else if (roll < 15) begin
                if ($urandom_range(1)) c = $urandom_range(127, n + 2);
                else r = $urandom_range(127, n + 2);
                send_item(make_item($urandom_range(1) ? gsgs_pkg::CMD_LOAD
                                                      : gsgs_pkg::CMD_READ, c, r));
            end else if (roll < 18) begin
                send_item(make_item(CMD_NOP, $urandom, $urandom));
            end else if (roll < 60 && mirror.loaded[mirror.at(c, r)]) begin
                send_item(make_item(gsgs_pkg::CMD_READ, c, r));
            end else begin
                send_item(make_item(gsgs_pkg::CMD_LOAD, c, r));
            end
        end
        drain();
    endtask

    initial begin
        gsgs_pkg::t_in it;
        mirror = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full grid extremes, out-of-range cells, idle command.
        it = '{gsgs_pkg::CMD_LOAD, 7'd0, 7'd0, 32'sh7fffffff, 32'sh80000000};
        send_item(it);
        it = '{gsgs_pkg::CMD_LOAD, 7'd65, 7'd65, 32'sh80000000, 32'sh7fffffff};
        send_item(it);
        send_item('{gsgs_pkg::CMD_READ, 7'd0, 7'd0, 32'sh0, 32'sh0});
        send_item('{gsgs_pkg::CMD_READ, 7'd65, 7'd65, 32'shffffffff, 32'shffffffff});
        send_item('{gsgs_pkg::CMD_LOAD, 7'd66, 7'd3, 32'sh1234, 32'sh5678});
        send_item('{gsgs_pkg::CMD_READ, 7'd127, 7'd127, 32'sh0, 32'sh0});
        send_item('{CMD_NOP, 7'd127, 7'd127, 32'shffffffff, 32'shffffffff});
        drain();

        // Directed: smallest grid with saturating coefficients and negated edges.
        write_reg(gsgs_pkg::REG_GRID_N, 32'd1);
        write_reg(gsgs_pkg::REG_BOUNDARY, {30'd0, gsgs_pkg::BND_NEG_LR});
        write_reg(gsgs_pkg::REG_COUPLING, 32'hffffffff);
        write_reg(gsgs_pkg::REG_INV_C, 32'h80000000);
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
                send_item('{gsgs_pkg::CMD_LOAD, 7'(i), 7'(j),
                            (i + j) % 2 ? 32'sh80000000 : 32'sh7fffffff, 32'sh80000000});
        send_item('{gsgs_pkg::CMD_SOLVE, 7'd127, 7'd127, 32'sh0, 32'sh0});
        send_item('{gsgs_pkg::CMD_READ, 7'd1, 7'd1, 32'sh0, 32'sh0});
        send_item('{gsgs_pkg::CMD_READ, 7'd0, 7'd1, 32'sh0, 32'sh0});
        send_item('{gsgs_pkg::CMD_READ, 7'd0, 7'd0, 32'sh0, 32'sh0});
        drain();
        write_reg(gsgs_pkg::REG_BOUNDARY, {30'd0, gsgs_pkg::BND_NEG_TB});
        write_reg(gsgs_pkg::REG_COUPLING, 32'd0);
        send_item('{gsgs_pkg::CMD_SOLVE, 7'd0, 7'd0, 32'sh0, 32'sh0});
        send_item('{gsgs_pkg::CMD_READ, 7'd1, 7'd0, 32'sh0, 32'sh0});
        drain();
        write_reg(gsgs_pkg::REG_BOUNDARY, {30'd0, BND_MIRROR_ALT});

        // Random phases: sender idles less, then more, then neither idles.
        while (items_sent < ITEM_GOAL) begin
            if (items_sent > 2 * ITEM_GOAL / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (items_sent > ITEM_GOAL / 3) begin
                send_idle = 72;
                recv_idle = 19;
            end
            run_phase();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (mirror.fails == 0 && mirror.expected_readouts.size() == 0) begin
            $display("gauss_seidel_grid_solver test passed");
        end else begin
            $display("gauss_seidel_grid_solver test failed");
        end
        $finish;
    end

endmodule
